/* rtl/gamepad_drive_command_mapper_core_defines.svh */
// Assertion macros for the gamepad drive command mapper checker.
// No dependencies; include by bare file name.
`ifndef GAMEPAD_DRIVE_COMMAND_MAPPER_CORE_DEFINES_SVH
`define GAMEPAD_DRIVE_COMMAND_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define GDCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gdcm check failed");

// Next-cycle implication, disabled while reset is low.
`define GDCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gdcm check failed");

`endif

/* rtl/gdcm_pkg.sv */
// Shared types and constants for the gamepad drive command mapper.
// No dependencies.
package gdcm_pkg;

    localparam int unsigned LIGHT_EFFECT_COUNT_DEF = 6;
    localparam int unsigned MAX_SPEED_LEVEL_DEF    = 6;
    localparam int unsigned ANGLE_WIDTH_DEF        = 16;

    localparam logic [7:0] ANALOG_MODE  = 8'h73;
    localparam logic [7:0] STICK_CENTRE = 8'd128;

    localparam logic [2:0] SPEED_LEVEL_MIN   = 3'd1;
    localparam logic [2:0] SPEED_LEVEL_RESET = 3'd5;
    localparam logic [4:0] JOINT_STEP_MIN    = 5'd5;
    localparam logic [4:0] JOINT_STEP_MAX    = 5'd25;
    localparam logic [4:0] JOINT_STEP_INC    = 5'd5;
    localparam logic [4:0] JOINT_STEP_RESET  = 5'd15;

    // Button bit positions, low byte
    localparam int unsigned BTN_SELECT = 0;
    localparam int unsigned BTN_SLOWER = 1;
    localparam int unsigned BTN_FASTER = 2;
    localparam int unsigned BTN_UP     = 4;
    localparam int unsigned BTN_RIGHT  = 5;
    localparam int unsigned BTN_DOWN   = 6;
    localparam int unsigned BTN_LEFT   = 7;
    // Button bit positions, high byte
    localparam int unsigned BTN_L2 = 0;
    localparam int unsigned BTN_L1 = 2;

    // x/10 as (x * 6554) >> 16, exact for x below 16384
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    localparam int unsigned DIV10_SHIFT = 16;

    typedef struct packed {
        logic [7:0] pad_mode;
        logic [7:0] buttons_low;
        logic [7:0] buttons_high;
        logic [7:0] right_stick_vertical;
        logic [7:0] left_stick_horizontal;
    } t_frame;

    typedef struct packed {
        logic select;
        logic slower;
        logic faster;
        logic joint_faster;
        logic joint_slower;
    } t_btn_flags;

    typedef struct packed {
        logic [2:0] speed_level;
        logic [4:0] joint_step;
        logic [2:0] effect_index;
        t_btn_flags flags;
    } t_level_state;

    localparam t_level_state LEVEL_STATE_RESET = '{
        speed_level:  SPEED_LEVEL_RESET,
        joint_step:   JOINT_STEP_RESET,
        effect_index: 3'd0,
        flags:        '0
    };

endpackage

/* rtl/gdcm_frame_reg.sv */
// Input register for one gamepad frame with upstream stall.
// Depends on gdcm_pkg.
module gdcm_frame_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  gdcm_pkg::t_frame i_frame,
    input  logic            i_advance,
    output logic            o_valid,
    output gdcm_pkg::t_frame o_frame
);
    import gdcm_pkg::*;

    logic   r_valid;
    t_frame r_frame;

    // Hold while a frame sits here and cannot move on
    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_frame <= i_frame;
        end
    end

endmodule

/* rtl/gdcm_drive_cmd.sv */
// Forward and turn commands from speed level and stick axes.
// Depends on gdcm_pkg.
module gdcm_drive_cmd (
    input  logic [2:0]        i_level,
    input  logic [7:0]        i_vert,
    input  logic [7:0]        i_horz,
    output logic signed [10:0] o_forward,
    output logic signed [8:0]  o_turn
);
    import gdcm_pkg::*;

    logic        v_neg;
    logic        h_neg;
    logic [7:0]  v_mag;
    logic [7:0]  h_mag;
    logic [9:0]  fwd_mag;
    logic [11:0] trn_lh;
    logic [11:0] trn_mag;
    logic [24:0] trn_scaled;
    logic [8:0]  trn_quot;

    always_comb begin
        v_neg   = i_vert > STICK_CENTRE;
        h_neg   = i_horz > STICK_CENTRE;
        v_mag   = v_neg ? (i_vert - STICK_CENTRE) : (STICK_CENTRE - i_vert);
        h_mag   = h_neg ? (i_horz - STICK_CENTRE) : (STICK_CENTRE - i_horz);
        fwd_mag = 10'(i_level) * 10'(v_mag);
        trn_lh  = 12'(i_level) * 12'(h_mag);
        trn_mag = {trn_lh[10:0], 1'b0} + trn_lh;
        // Truncate toward zero: divide the magnitude, then apply the sign
        trn_scaled = 25'(trn_mag) * 25'(DIV10_RECIP);
        trn_quot   = trn_scaled[DIV10_SHIFT +: 9];

        o_forward = v_neg ? (11'd0 - 11'(fwd_mag)) : 11'(fwd_mag);

        if (!h_neg) begin
            o_turn = trn_quot[8] ? 9'sd255 : {1'b0, trn_quot[7:0]};
        end else begin
            o_turn = (trn_quot > 9'd256) ? 9'h100 : (9'd0 - trn_quot);
        end
    end

endmodule

/* rtl/gdcm_button_ctrl.sv */
// Button release edges: speed level, joint step, light effect and beep.
// Depends on gdcm_pkg.
module gdcm_button_ctrl #(
    parameter int unsigned LIGHT_EFFECT_COUNT = gdcm_pkg::LIGHT_EFFECT_COUNT_DEF,
    parameter int unsigned MAX_SPEED_LEVEL    = gdcm_pkg::MAX_SPEED_LEVEL_DEF
) (
    input  gdcm_pkg::t_level_state i_cur,
    input  logic [7:0]             i_buttons_low,
    input  logic [7:0]             i_buttons_high,
    output gdcm_pkg::t_level_state o_next,
    output logic                   o_beep
);
    import gdcm_pkg::*;

    localparam logic [2:0] EFFECT_LAST = 3'(LIGHT_EFFECT_COUNT - 1);
    localparam logic [2:0] SPEED_TOP   = 3'(MAX_SPEED_LEVEL);

    t_btn_flags pressed;
    t_btn_flags released;
    logic [2:0] lvl_mid;

    always_comb begin
        pressed.select       = i_buttons_low[BTN_SELECT];
        pressed.slower       = i_buttons_low[BTN_SLOWER];
        pressed.faster       = i_buttons_low[BTN_FASTER];
        pressed.joint_faster = i_buttons_high[BTN_L1];
        pressed.joint_slower = i_buttons_high[BTN_L2];
        released = i_cur.flags & ~pressed;

        o_next       = i_cur;
        o_next.flags = pressed;
        o_beep       = 1'b0;

        if (released.select) begin
            o_next.effect_index = (i_cur.effect_index >= EFFECT_LAST) ? 3'd0
                                                                      : i_cur.effect_index + 3'd1;
        end

        // Slower first, then faster on the result
        lvl_mid = i_cur.speed_level;
        if (released.slower) begin
            if (i_cur.speed_level > SPEED_LEVEL_MIN) begin
                lvl_mid = i_cur.speed_level - 3'd1;
            end else begin
                lvl_mid = SPEED_LEVEL_MIN;
                o_beep  = 1'b1;
            end
        end
        o_next.speed_level = lvl_mid;
        if (released.faster) begin
            if (lvl_mid < SPEED_TOP) begin
                o_next.speed_level = lvl_mid + 3'd1;
            end else begin
                o_next.speed_level = SPEED_TOP;
                o_beep             = 1'b1;
            end
        end

        if (released.joint_faster) begin
            if (i_cur.joint_step < JOINT_STEP_MAX) begin
                o_next.joint_step = i_cur.joint_step + JOINT_STEP_INC;
            end else begin
                o_next.joint_step = JOINT_STEP_MAX;
                o_beep            = 1'b1;
            end
        end
        if (released.joint_slower) begin
            if (o_next.joint_step > JOINT_STEP_MIN) begin
                o_next.joint_step = o_next.joint_step - JOINT_STEP_INC;
            end else begin
                o_next.joint_step = JOINT_STEP_MIN;
                o_beep            = 1'b1;
            end
        end
    end

endmodule

/* rtl/gamepad_drive_command_mapper_core.sv */
// Gamepad drive command mapper, top level.
// Depends on gdcm_pkg, gdcm_frame_reg, gdcm_drive_cmd, gdcm_button_ctrl.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------
//   frame in | input     | i_in_valid / o_in_stall    | mode, two button bytes, axes
//   result   | output    | o_out_valid / i_out_stall  | commands, levels, angles, flags
//
// One frame per cycle while the result is not stalled; a frame taken in goes through the
// input register and then the result registers before it can be taken downstream.
// The mapper state doubles as the result register, so a result changes only when
// the next frame moves out of the input register.
// Reset is synchronous, active low; it clears both valids and restores all levels.
// A stalled result stalls the input only once the input register is also full.
module gamepad_drive_command_mapper_core #(
    parameter int unsigned LIGHT_EFFECT_COUNT = gdcm_pkg::LIGHT_EFFECT_COUNT_DEF,
    parameter int unsigned MAX_SPEED_LEVEL    = gdcm_pkg::MAX_SPEED_LEVEL_DEF,
    parameter int unsigned ANGLE_WIDTH        = gdcm_pkg::ANGLE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_pad_mode,
    input  logic [7:0]        i_buttons_low,
    input  logic [7:0]        i_buttons_high,
    input  logic [7:0]        i_right_stick_vertical,
    input  logic [7:0]        i_left_stick_horizontal,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [10:0] o_forward_speed,
    output logic signed [8:0]  o_turn_rate,
    output logic [2:0]        o_light_effect,
    output logic signed [15:0] o_pan_joint_angle,
    output logic signed [15:0] o_tilt_joint_angle,
    output logic [2:0]        o_speed_setting,
    output logic [4:0]        o_joint_speed,
    output logic              o_beep_request,
    output logic              o_frame_applied
);
    import gdcm_pkg::*;

    t_frame       in_frame;
    t_frame       cur_frame;
    logic         cur_valid;
    logic         advance;
    logic         applied;

    logic                   r_out_valid;
    t_level_state           r_lvl;
    logic [ANGLE_WIDTH-1:0] r_pan;
    logic [ANGLE_WIDTH-1:0] r_tilt;
    logic signed [10:0]     r_forward;
    logic signed [8:0]      r_turn;
    logic                   r_beep;
    logic                   r_applied;

    t_level_state           n_lvl;
    logic [ANGLE_WIDTH-1:0] n_pan;
    logic [ANGLE_WIDTH-1:0] n_tilt;
    logic signed [10:0]     n_forward;
    logic signed [8:0]      n_turn;
    logic                   n_beep;
    logic [ANGLE_WIDTH-1:0] step_ext;

    assign in_frame = '{
        pad_mode:              i_pad_mode,
        buttons_low:           i_buttons_low,
        buttons_high:          i_buttons_high,
        right_stick_vertical:  i_right_stick_vertical,
        left_stick_horizontal: i_left_stick_horizontal
    };

    // Advance when the result slot is empty or its beat is being taken
    assign advance = cur_valid && (!r_out_valid || !i_out_stall);
    assign applied = (cur_frame.pad_mode == ANALOG_MODE);

    gdcm_frame_reg u_frame_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_frame   (in_frame),
        .i_advance (advance),
        .o_valid   (cur_valid),
        .o_frame   (cur_frame)
    );

    // Both commands use the level from before this frame's edges
    gdcm_drive_cmd u_drive_cmd (
        .i_level   (r_lvl.speed_level),
        .i_vert    (cur_frame.right_stick_vertical),
        .i_horz    (cur_frame.left_stick_horizontal),
        .o_forward (n_forward),
        .o_turn    (n_turn)
    );

    gdcm_button_ctrl #(
        .LIGHT_EFFECT_COUNT (LIGHT_EFFECT_COUNT),
        .MAX_SPEED_LEVEL    (MAX_SPEED_LEVEL)
    ) u_button_ctrl (
        .i_cur          (r_lvl),
        .i_buttons_low  (cur_frame.buttons_low),
        .i_buttons_high (cur_frame.buttons_high),
        .o_next         (n_lvl),
        .o_beep         (n_beep)
    );

    // Joints move by the step from before this frame's joint-step button edges
    always_comb begin
        step_ext = ANGLE_WIDTH'(r_lvl.joint_step);
        n_pan    = r_pan;
        n_tilt   = r_tilt;
        if (cur_frame.buttons_low[BTN_LEFT]) begin
            n_pan = r_pan + step_ext;
        end else if (cur_frame.buttons_low[BTN_RIGHT]) begin
            n_pan = r_pan - step_ext;
        end
        if (cur_frame.buttons_low[BTN_DOWN]) begin
            n_tilt = r_tilt + step_ext;
        end else if (cur_frame.buttons_low[BTN_UP]) begin
            n_tilt = r_tilt - step_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_lvl       <= LEVEL_STATE_RESET;
            r_pan       <= '0;
            r_tilt      <= '0;
            r_forward   <= '0;
            r_turn      <= '0;
            r_beep      <= 1'b0;
            r_applied   <= 1'b0;
        end else begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= cur_valid;
            end
            if (advance) begin
                r_beep    <= applied && n_beep;
                r_applied <= applied;
                // Ignored frames keep every state entry
                if (applied) begin
                    r_lvl     <= n_lvl;
                    r_pan     <= n_pan;
                    r_tilt    <= n_tilt;
                    r_forward <= n_forward;
                    r_turn    <= n_turn;
                end
            end
        end
    end

    generate
        if (ANGLE_WIDTH >= 16) begin : g_angle_wide
            assign o_pan_joint_angle  = r_pan[15:0];
            assign o_tilt_joint_angle = r_tilt[15:0];
        end else begin : g_angle_narrow
            assign o_pan_joint_angle  = {{(16 - ANGLE_WIDTH){1'b0}}, r_pan};
            assign o_tilt_joint_angle = {{(16 - ANGLE_WIDTH){1'b0}}, r_tilt};
        end
    endgenerate

    assign o_out_valid     = r_out_valid;
    assign o_forward_speed = r_forward;
    assign o_turn_rate     = r_turn;
    assign o_light_effect  = r_lvl.effect_index;
    assign o_speed_setting = r_lvl.speed_level;
    assign o_joint_speed   = r_lvl.joint_step;
    assign o_beep_request  = r_beep;
    assign o_frame_applied = r_applied;

endmodule

/* rtl/gdcm_checker.sv */
// Port-level checks for the gamepad drive command mapper, bound to the top level.
// Depends on gamepad_drive_command_mapper_core_defines.svh.
`include "gamepad_drive_command_mapper_core_defines.svh"

module gdcm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic signed [10:0] o_forward_speed,
    input logic signed [8:0]  o_turn_rate,
    input logic signed [15:0] o_pan_joint_angle,
    input logic [2:0]        o_speed_setting,
    input logic [4:0]        o_joint_speed,
    input logic              o_beep_request,
    input logic              o_frame_applied
);

    // A stalled beat holds
    `GDCM_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_forward_speed) && $stable(o_pan_joint_angle) && $stable(o_beep_request))

    // Beep only on a frame that was used
    `GDCM_ASSERT_IMP(a_beep_applied, i_clk, i_rst_n, o_out_valid && !o_frame_applied, !o_beep_request)

    // An ignored frame repeats the state of the beat before it
    `GDCM_ASSERT_IMP(a_ignored_holds, i_clk, i_rst_n, (o_out_valid && !i_out_stall) ##1 (o_out_valid && !o_frame_applied), $stable(o_speed_setting) && $stable(o_joint_speed) && $stable(o_forward_speed) && $stable(o_turn_rate))

    // Joint step stays on its grid
    `GDCM_ASSERT_IMP(a_joint_grid, i_clk, i_rst_n, o_out_valid, o_joint_speed == 5'd5 || o_joint_speed == 5'd10 || o_joint_speed == 5'd15 || o_joint_speed == 5'd20 || o_joint_speed == 5'd25)

endmodule

bind gamepad_drive_command_mapper_core gdcm_checker u_gdcm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_forward_speed   (o_forward_speed),
    .o_turn_rate       (o_turn_rate),
    .o_pan_joint_angle (o_pan_joint_angle),
    .o_speed_setting   (o_speed_setting),
    .o_joint_speed     (o_joint_speed),
    .o_beep_request    (o_beep_request),
    .o_frame_applied   (o_frame_applied)
);
